[hdl/assert_macros.svh]
// Assertion helpers used by the sequencer core.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

[hdl/ssds_pkg.sv]
`default_nettype none

package ssds_pkg;

    // Command and address bytes of the driver protocol
    localparam logic [7:0] CMD_DATA     = 8'h44;
    localparam logic [7:0] GRID_BASE    = 8'hc0;
    localparam logic [7:0] COLON_BIT    = 8'h80;
    localparam logic [7:0] CTRL_RESET   = 8'h8a;

    // Request modes
    localparam logic [1:0] MODE_VALUE   = 2'd0;

    // Position of the display-control byte, the last one of a sequence
    localparam logic [3:0] IDX_LAST     = 4'd9;

    // Four digits, index 0 is the leftmost grid
    typedef logic [3:0][3:0] digit_set_t;

    // Four segment patterns, index 0 is grid 0
    typedef logic [3:0][7:0] seg_set_t;

    // One output byte with its framing flags
    typedef struct packed {
        logic [7:0] out_byte;
        logic       start_before;
        logic       stop_after;
        logic       last;
    } res_t;

endpackage

`default_nettype wire

[hdl/ssds_emit.sv]
`default_nettype none

// Sends the ten bytes of one request, one byte per cycle.
module ssds_emit
    import ssds_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        pat_valid,
    input  wire seg_set_t pat,
    input  wire [7:0]  ctrl,
    output logic       take,
    output logic       strobe,
    output res_t       res
);

    logic       active_reg;
    logic       active_next;
    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    seg_set_t   pat_reg;
    logic [1:0] grid;

    // Free for a new pattern set when idle or on the final byte
    assign take   = !active_reg || (idx_reg == IDX_LAST);
    assign strobe = active_reg;

    // Byte counter
    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        if (take && pat_valid)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
        else if (take)
        begin
            active_next = 1'b0;
        end
        else
        begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    // Pattern hold
    always_ff @(posedge clk)
    begin
        if (take && pat_valid)
        begin
            pat_reg <= pat;
        end
    end

    // Byte decode: in 1-8, odd positions grid addresses, even segment bytes
    always_comb
    begin
        grid             = idx_reg[2:1];
        res.out_byte     = CMD_DATA;
        res.start_before = 1'b1;
        res.stop_after   = 1'b1;
        res.last         = 1'b0;
        if (idx_reg == IDX_LAST)
        begin
            res.out_byte = ctrl;
            res.last     = 1'b1;
        end
        else if (idx_reg != '0)
        begin
            if (idx_reg[0])
            begin
                res.out_byte   = GRID_BASE | {6'd0, grid};
                res.stop_after = 1'b0;
            end
            else
            begin
                res.out_byte     = pat_reg[grid - 2'd1];
                res.start_before = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/seven_segment_display_sequencer_core.sv]
`default_nettype none
// Four-digit seven-segment display command sequencer.
//
// Request channel: drive mode, value and the four digit fields with start
// high; the request is taken at a rising clk edge where start is high and
// busy is low. Mode 0 shows the low four decimal digits of value, mode 1
// the four digits, modes 2 and 3 the digits with the colon on grid 1.
// Config: display_control is written at any edge with cfg_we high.
// Result channel: ten bytes per request, one per cycle on consecutive
// cycles, each valid for one cycle while out_strobe is high. A request
// passes the stage 1, 2, 3 and 4 registers in order and then waits for the
// output to be free before its first byte shows. Throughput is set by the
// ten-byte output counter; up to four further requests wait in the
// conversion pipeline, and busy rises only when all of it is full.
// The receiver cannot stall; bytes are never held back.
// Reset: all stages empty, no output, display_control back to 0x8a.
`include "assert_macros.svh"

module seven_segment_display_sequencer_core
    import ssds_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    output logic       busy,
    input  wire [1:0]  mode,
    input  wire [15:0] value,
    input  wire [3:0]  digit_left,
    input  wire [3:0]  digit_second,
    input  wire [3:0]  digit_third,
    input  wire [3:0]  digit_right,
    input  wire        cfg_we,
    input  wire [7:0]  cfg_data,
    output logic       out_strobe,
    output logic [7:0] out_byte,
    output logic       start_before,
    output logic       stop_after,
    output logic       last
);

    // One shift-add-3 step of binary to BCD, four digits kept
    function automatic logic [15:0] dabble_step(input logic [15:0] bcd, input logic din);
        logic [15:0] adj;
        adj = bcd;
        for (int k = 0; k < 4; k++)
        begin
            if (adj[4*k +: 4] >= 4'd5)
            begin
                adj[4*k +: 4] = adj[4*k +: 4] + 4'd3;
            end
        end
        return {adj[14:0], din};
    endfunction

    // Eight steps, MSB first
    function automatic logic [15:0] dabble_byte(input logic [15:0] bcd,
                                                input logic [7:0] bits);
        logic [15:0] acc;
        acc = bcd;
        for (int i = 7; i >= 0; i--)
        begin
            acc = dabble_step(acc, bits[i]);
        end
        return acc;
    endfunction

    function automatic logic [7:0] seg_lookup(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'h3f;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5b;
            4'd3:    p = 8'h4f;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6d;
            4'd6:    p = 8'h7d;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7f;
            4'd9:    p = 8'h6f;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

    logic [7:0]  ctrl_val_reg;

    logic        s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic        s1_v_next, s2_v_next, s3_v_next, s4_v_next;
    logic        s1_ready, s2_ready, s3_ready, s4_ready;
    logic        accept;
    logic        take;

    logic [1:0]  s1_mode_reg, s2_mode_reg, s3_mode_reg;
    logic [15:0] s1_value_reg;
    logic [7:0]  s2_low_reg;
    logic [15:0] s2_bcd_reg, s3_bcd_reg;
    digit_set_t  s1_dig_reg, s2_dig_reg, s3_dig_reg;
    seg_set_t    s4_pat_reg;

    digit_set_t  s3_sel;
    seg_set_t    s3_pat;
    res_t        res;

    logic        cmd_head;
    logic        pipe_full;

    // Display-control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_val_reg <= CTRL_RESET;
        end
        else if (cfg_we)
        begin
            ctrl_val_reg <= cfg_data;
        end
    end

    // Ready chain from the output back to the request port
    assign s4_ready = !s4_v_reg || take;
    assign s3_ready = !s3_v_reg || s4_ready;
    assign s2_ready = !s2_v_reg || s3_ready;
    assign s1_ready = !s1_v_reg || s2_ready;
    assign busy     = !s1_ready;
    assign accept   = start && s1_ready;

    // Stage valid bits
    always_comb
    begin
        s1_v_next = s1_ready ? accept   : s1_v_reg;
        s2_v_next = s2_ready ? s1_v_reg : s2_v_reg;
        s3_v_next = s3_ready ? s2_v_reg : s3_v_reg;
        s4_v_next = s4_ready ? s3_v_reg : s4_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s2_v_next;
            s3_v_reg <= s3_v_next;
            s4_v_reg <= s4_v_next;
        end
    end

    // Stage 1: request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg  <= mode;
            s1_value_reg <= value;
            s1_dig_reg   <= {digit_right, digit_third, digit_second, digit_left};
        end
    end

    // Stage 2: BCD conversion of the high byte
    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_low_reg  <= s1_value_reg[7:0];
            s2_bcd_reg  <= dabble_byte(16'd0, s1_value_reg[15:8]);
            s2_dig_reg  <= s1_dig_reg;
        end
    end

    // Stage 3: BCD conversion of the low byte
    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_mode_reg <= s2_mode_reg;
            s3_bcd_reg  <= dabble_byte(s2_bcd_reg, s2_low_reg);
            s3_dig_reg  <= s2_dig_reg;
        end
    end

    // Stage 4: digit select, segment lookup, colon
    always_comb
    begin
        if (s3_mode_reg == MODE_VALUE)
        begin
            s3_sel = {s3_bcd_reg[3:0], s3_bcd_reg[7:4], s3_bcd_reg[11:8], s3_bcd_reg[15:12]};
        end
        else
        begin
            s3_sel = s3_dig_reg;
        end
        for (int k = 0; k < 4; k++)
        begin
            s3_pat[k] = seg_lookup(s3_sel[k]);
        end
        if (s3_mode_reg[1])
        begin
            s3_pat[1] = s3_pat[1] | COLON_BIT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready)
        begin
            s4_pat_reg <= s3_pat;
        end
    end

    // Byte sequencer
    ssds_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .pat_valid (s4_v_reg),
        .pat       (s4_pat_reg),
        .ctrl      (ctrl_val_reg),
        .take      (take),
        .strobe    (out_strobe),
        .res       (res)
    );

    assign out_byte     = res.out_byte;
    assign start_before = res.start_before;
    assign stop_after   = res.stop_after;
    assign last         = res.last;

    // Checks
    assign cmd_head  = (out_byte == CMD_DATA) && start_before && stop_after;
    assign pipe_full = s2_v_reg && s3_v_reg && s4_v_reg && !take;

    `ASSERT_CLK(a_seq_contig, out_strobe && !last |=> out_strobe, "sequence broke before last byte")
    `ASSERT_CLK(a_seq_head, $rose(out_strobe) |-> cmd_head, "sequence opened without data command")
    `ASSERT_CLK(a_last_ctrl, out_strobe && last |-> out_byte == ctrl_val_reg, "last byte not control")
    `ASSERT_NEVER(a_busy_full, busy && !pipe_full, "busy with room in pipeline")

endmodule

`default_nettype wire

[dv/seven_segment_display_sequencer_core_tb.sv]
`timescale 1ns / 100ps

module seven_segment_display_sequencer_core_tb;
    import ssds_pkg::*;

    // Request modes beyond the one the package names
    localparam logic [1:0] MODE_DIGITS = 2'd1;
    localparam logic [1:0] MODE_COLON  = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 116;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [15:0] value;
    logic [3:0]  digit_left;
    logic [3:0]  digit_second;
    logic [3:0]  digit_third;
    logic [3:0]  digit_right;
    logic        cfg_we;
    logic [7:0]  cfg_data;
    logic        out_strobe;
    logic [7:0]  out_byte;
    logic        start_before;
    logic        stop_after;
    logic        last;

    // Predictor state and scoreboard
    logic [7:0] display_ctrl;
    res_t       expected_bytes [$];
    int         requests_sent;
    int         bytes_checked;
    int         settings_used;
    int         error_count;

    seven_segment_display_sequencer_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .value        (value),
        .digit_left   (digit_left),
        .digit_second (digit_second),
        .digit_third  (digit_third),
        .digit_right  (digit_right),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .out_strobe   (out_strobe),
        .out_byte     (out_byte),
        .start_before (start_before),
        .stop_after   (stop_after),
        .last         (last)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: timeout, %0d bytes still expected", $time, expected_bytes.size());
        $display("seven_segment_display_sequencer_core test failed");
        $finish;
    end

    // Build the ten-byte command sequence for one request
    function automatic void predict_sequence(input logic [1:0] req_mode,
                                             input logic [15:0] req_value,
                                             input logic [3:0] d0, input logic [3:0] d1,
                                             input logic [3:0] d2, input logic [3:0] d3);
        logic [3:0] dig [4];
        logic [7:0] pat [4];
        int         k;
        if (req_mode == MODE_VALUE)
        begin
            dig[0] = 4'((req_value / 1000) % 10);
            dig[1] = 4'((req_value / 100) % 10);
            dig[2] = 4'((req_value / 10) % 10);
            dig[3] = 4'(req_value % 10);
        end
        else
        begin
            dig[0] = d0;
            dig[1] = d1;
            dig[2] = d2;
            dig[3] = d3;
        end
        for (k = 0; k < 4; k++)
        begin
            case (dig[k])
                4'd0:    pat[k] = 8'h3f;
                4'd1:    pat[k] = 8'h06;
                4'd2:    pat[k] = 8'h5b;
                4'd3:    pat[k] = 8'h4f;
                4'd4:    pat[k] = 8'h66;
                4'd5:    pat[k] = 8'h6d;
                4'd6:    pat[k] = 8'h7d;
                4'd7:    pat[k] = 8'h07;
                4'd8:    pat[k] = 8'h7f;
                4'd9:    pat[k] = 8'h6f;
                default: pat[k] = 8'h00;   // blank above nine
            endcase
        end
        // colon modes put the colon on grid 1
        if (req_mode >= MODE_COLON)
            pat[1] = pat[1] | COLON_BIT;
        expected_bytes.push_back('{CMD_DATA, 1'b1, 1'b1, 1'b0});
        for (k = 0; k < 4; k++)
        begin
            expected_bytes.push_back('{GRID_BASE + 8'(k), 1'b1, 1'b0, 1'b0});
            expected_bytes.push_back('{pat[k], 1'b0, 1'b1, 1'b0});
        end
        expected_bytes.push_back('{display_ctrl, 1'b1, 1'b1, 1'b1});
    endfunction

    // Send one request; returns at the accepting edge with start still high
    task automatic send_request(input logic [1:0] req_mode, input logic [15:0] req_value,
                                input logic [3:0] d0, input logic [3:0] d1,
                                input logic [3:0] d2, input logic [3:0] d3);
        start        <= 1'b1;
        mode         <= req_mode;
        value        <= req_value;
        digit_left   <= d0;
        digit_second <= d1;
        digit_third  <= d2;
        digit_right  <= d3;
        do
            @(posedge clk);
        while (busy);
        predict_sequence(req_mode, req_value, d0, d1, d2, d3);
        requests_sent++;
    endtask

    task automatic send_random_request();
        send_request(2'($urandom_range(0, 2)), 16'($urandom_range(0, 65535)),
                     4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                     4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)));
    endtask

    // Random sender gap: geometric, with an occasional long pause
    task automatic pause_sender(input int idle_pct);
        int n;
        n = 0;
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct && n < 200)
            n++;
        if (idle_pct > 0 && $urandom_range(0, 19) == 0)
            n += $urandom_range(1, 40);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every expected byte has come out
    task automatic drain_requests();
        start <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write the display-control register while the block is idle
    task automatic write_control(input logic [7:0] ctrl);
        cfg_we   <= 1'b1;
        cfg_data <= ctrl;
        @(posedge clk);
        cfg_we       <= 1'b0;
        display_ctrl  = ctrl;
        settings_used++;
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Compare every output byte with the oldest expectation
    always @(posedge clk)
    begin : check_bytes
        res_t exp_r;
        if (rst_n && out_strobe)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte, expected none, actual 0x%0h", $time, out_byte);
                error_count++;
            end
            else
            begin
                exp_r = expected_bytes.pop_front();
                check_field("out_byte", int'(exp_r.out_byte), int'(out_byte));
                check_field("start_before", int'(exp_r.start_before), int'(start_before));
                check_field("stop_after", int'(exp_r.stop_after), int'(stop_after));
                check_field("last", int'(exp_r.last), int'(last));
                bytes_checked++;
            end
        end
    end

    // Control byte straight out of reset
    task automatic test_reset_control();
        repeat (3) send_random_request();
        drain_requests();
    endtask

    // Number mode: extremes and carries across decimal digits
    task automatic test_value_mode();
        send_request(MODE_VALUE, 16'd0, 4'd9, 4'd9, 4'd9, 4'd9);
        send_request(MODE_VALUE, 16'hffff, 4'd0, 4'd0, 4'd0, 4'd0);
        send_request(MODE_VALUE, 16'd9999, 4'd7, 4'd8, 4'd1, 4'd2);
        send_request(MODE_VALUE, 16'd10000, 4'd3, 4'd4, 4'd5, 4'd6);
        send_request(MODE_VALUE, 16'd1234, 4'd0, 4'd9, 4'd0, 4'd9);
        send_request(MODE_VALUE, 16'h5a5a, 4'd8, 4'd8, 4'd8, 4'd8);
        drain_requests();
    endtask

    // Explicit digits, with and without colon; value is don't-care
    task automatic test_digit_modes();
        send_request(MODE_DIGITS, 16'hffff, 4'd0, 4'd0, 4'd0, 4'd0);
        send_request(MODE_DIGITS, 16'd0, 4'd9, 4'd9, 4'd9, 4'd9);
        send_request(MODE_DIGITS, 16'h1234, 4'd7, 4'd7, 4'd7, 4'd7);
        send_request(MODE_DIGITS, 16'd42, 4'd8, 4'd1, 4'd2, 4'd3);
        send_request(MODE_COLON, 16'd0, 4'd1, 4'd2, 4'd3, 4'd4);
        send_request(MODE_COLON, 16'hffff, 4'd0, 4'd0, 4'd0, 4'd0);
        send_request(MODE_COLON, 16'h8000, 4'd9, 4'd8, 4'd7, 4'd6);
        drain_requests();
    endtask

    // Spare mode acts as colon mode; digits above nine go blank
    task automatic test_open_cases();
        send_request(MODE_SPARE, 16'd1234, 4'd5, 4'd6, 4'd7, 4'd8);
        send_request(MODE_DIGITS, 16'd0, 4'd10, 4'd11, 4'd12, 4'd15);
        send_request(MODE_COLON, 16'd0, 4'd3, 4'd15, 4'd13, 4'd1);
        send_request(MODE_SPARE, 16'd0, 4'd14, 4'd10, 4'd2, 4'd9);
        drain_requests();
    endtask

    // Control byte at 0x80, at 0x8f and in between at 0x88
    task automatic test_control_settings();
        write_control(8'h80);
        repeat (2) send_random_request();
        drain_requests();
        write_control(8'h8f);
        repeat (2) send_random_request();
        drain_requests();
        write_control(8'h88);
        repeat (2) send_random_request();
        drain_requests();
    endtask

    // Random requests over several sender idling phases
    task automatic test_random_traffic();
        int idle_pct [4];
        int p;
        // phases 0 and 2 send without pauses; the receiver cannot stall this block
        idle_pct = '{0, 59, 0, 24};
        for (p = 0; p < 4; p++)
        begin
            write_control(8'($urandom_range(128, 143)));
            repeat (RANDOM_PER_PHASE)
            begin
                send_random_request();
                pause_sender(idle_pct[p]);
            end
            drain_requests();
        end
    endtask

    initial
    begin
        display_ctrl  = CTRL_RESET;
        requests_sent = 0;
        bytes_checked = 0;
        settings_used = 0;
        error_count   = 0;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        mode         <= MODE_VALUE;
        value        <= 16'd0;
        digit_left   <= 4'd0;
        digit_second <= 4'd0;
        digit_third  <= 4'd0;
        digit_right  <= 4'd0;
        cfg_we       <= 1'b0;
        cfg_data     <= 8'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_control();
        test_value_mode();
        test_digit_modes();
        test_open_cases();
        test_control_settings();
        test_random_traffic();

        // let any stray byte show up before judging
        drain_requests();
        repeat (30) @(posedge clk);

        $display("Sent %0d requests in all modes, checked %0d output bytes,", requests_sent,
                 bytes_checked);
        $display("over the reset control byte and %0d written settings; %0d errors.",
                 settings_used, error_count);
        if (error_count == 0)
            $display("seven_segment_display_sequencer_core test passed");
        else
            $display("seven_segment_display_sequencer_core test failed");
        $finish;
    end

endmodule
